// File: hdl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// PPS frequency discipline package
// Shared constants, register indexes and widths for the discipline loop.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int RING_DEPTH_DEF = 128;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_ADJUST   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_WRAP = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_HZ      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_PWM_START       = CFG_IDX_W'(3);

	// Register reset values.
	localparam logic [16:0] COUNTS_PER_WRAP_RST = 17'd65536;
	localparam logic [31:0] NOMINAL_HZ_RST      = 32'd72000000;
	localparam logic [15:0] PWM_START_RST       = 16'd32768;

	// Loop constants.
	localparam logic [31:0] PPS_TIMEOUT_MS = 32'd1300;
	localparam int          ERR_LIMIT      = 2000;
	localparam int          SQUARE_MIN     = 3;
	localparam logic [31:0] AVG_NO_SAMPLES = 32'h0000_FFFF;

	// Scale of 1e9 * 100 = 0x17_4876_E800, split at bit 20 for two narrow products.
	localparam int          SCALE_SPLIT = 20;
	localparam int          SCALE_W     = 37;
	localparam logic [31:0] SCALE_LO    = 32'h0006_E800;
	localparam logic [31:0] SCALE_HI    = 32'h0001_7487;

	// Field widths.
	localparam int ERR_W = 12;

endpackage

// File: hdl/pfd_if.sv
// ----------------------------------------------------------------------------
// PPS frequency discipline channels
// Valid/ready channels for events, results and configuration writes.
// ----------------------------------------------------------------------------
interface pfd_evt_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] capture_count;
	logic [31:0] now_ms;

	modport source (output valid, func, capture_count, now_ms, input ready);
	modport sink   (input valid, func, capture_count, now_ms, output ready);
endinterface

interface pfd_res_if;
	logic               valid;
	logic               ready;
	logic        [31:0] measured_cycles;
	logic signed [11:0] freq_error;
	logic        [15:0] pwm_compare;
	logic signed [31:0] avg_error_ppb_x100;
	logic        [7:0]  sample_count;

	modport source (output valid, measured_cycles, freq_error, pwm_compare,
		avg_error_ppb_x100, sample_count, input ready);
	modport sink   (input valid, measured_cycles, freq_error, pwm_compare,
		avg_error_ppb_x100, sample_count, output ready);
endinterface

interface pfd_cfg_if import pfd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/pfd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/pfd_div.sv
// ----------------------------------------------------------------------------
// Unsigned bit-serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfd_div #(
	parameter int NUM_W = 55,
	parameter int DEN_W = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [31:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;

	// The numerator shifts out of the top of quo_q while quotient bits enter below.
	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so it fits in DEN_W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q[31:0];

endmodule

// File: hdl/pps_frequency_discipline.sv
// ----------------------------------------------------------------------------
// PPS frequency discipline
// Measures cycles between PPS captures, trims the oscillator PWM value and
// reports the running average error in ppb x 100.
// ----------------------------------------------------------------------------
// Usage: events enter on evt (func 0 = timer wrap, func 1 = PPS capture) and
// each one yields exactly one result word on res, showing the state after the
// event. Configuration words on cfg are always taken and should only be sent
// while no event is in flight.
// A measuring PPS capture passes the states MULW, MEAS, SQUARE and TRIM and
// then DEN, NLO, NHI, DSTART, DWAIT and FIN; a wrap or a capture that does
// not measure goes straight to DEN. When no samples are held or the nominal
// rate is zero the divide is skipped and DSTART goes on to FIN. Almost all
// of the time is the bit-serial divider that forms the average; a shared
// 32x32 multiplier handles the measurement, the error square and the average
// scaling one product per cycle. evt.ready is high only between events, so
// the next event is taken at the earliest in the same cycle in which the
// result word appears.
// The result sits in an output register: a stalled receiver does not hold up
// the next event until its own result is ready, and then the block waits.
// Reset clears all loop state, loads the PWM value with its start value and
// empties the error ring; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pps_frequency_discipline
	import pfd_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	pfd_evt_if.sink evt,
	pfd_res_if.source res,
	pfd_cfg_if.sink cfg
);

	localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SAMP_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = ERR_W + PTR_W;
	localparam int NUM_W  = SUM_W - 1 + SCALE_W;
	localparam int DEN_W  = 32 + SAMP_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MULW   = 4'd1;
	localparam logic [3:0] ST_MEAS   = 4'd2;
	localparam logic [3:0] ST_SQUARE = 4'd3;
	localparam logic [3:0] ST_TRIM   = 4'd4;
	localparam logic [3:0] ST_DEN    = 4'd5;
	localparam logic [3:0] ST_NLO    = 4'd6;
	localparam logic [3:0] ST_NHI    = 4'd7;
	localparam logic [3:0] ST_DSTART = 4'd8;
	localparam logic [3:0] ST_DWAIT  = 4'd9;
	localparam logic [3:0] ST_FIN    = 4'd10;

	logic [3:0] state_q;

	// Configuration.
	logic        enable_q;
	logic [16:0] cpw_q;
	logic [31:0] nominal_q;

	// Loop state.
	logic [31:0]             wrap_q;
	logic [15:0]             prev_cap_q;
	logic [31:0]             last_ms_q;
	logic [31:0]             measured_q;
	logic                    first_q;
	logic [15:0]             pwm_q;
	logic [PTR_W-1:0]        ptr_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SAMP_W-1:0]       samples_q;

	// Work registers.
	logic [15:0]      cap_q;
	logic [31:0]      now_q;
	logic [63:0]      prod_q;
	logic [DEN_W-1:0] den_q;
	logic [63:0]      nlo_q;
	logic [31:0]      avg_q;

	// Output register.
	logic               res_valid_q;
	logic [31:0]        res_meas_q;
	logic signed [11:0] res_err_q;
	logic [15:0]        res_pwm_q;
	logic [31:0]        res_avg_q;
	logic [7:0]         res_samp_q;

	logic evt_acc;
	logic pps_ok;
	logic [31:0] mul_a;
	logic [31:0] mul_b;

	logic [31:0]             diff;
	logic                    err_ok;
	logic signed [ERR_W-1:0] err;
	logic                    err_neg;
	logic [10:0]             mag;
	logic signed [ERR_W-1:0] half_e;
	logic [15:0]             adj;
	logic                    ring_full;
	logic [ERR_W-1:0]        ram_rdata;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] err_ext;
	logic signed [SUM_W-1:0] sum_abs_full;
	logic [SUM_W-2:0]        sum_abs;
	logic                    sum_neg;
	logic [NUM_W-1:0]        num_w;
	logic                    div_start;
	logic                    div_done;
	logic [31:0]             div_quot;
	logic [31:0]             samp_ext;

	assign evt_acc   = evt.valid && evt.ready;
	assign evt.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// A measurement needs a previous PPS less than the timeout ago.
	assign pps_ok = !first_q && ((evt.now_ms - last_ms_q) < PPS_TIMEOUT_MS);

	// Error against nominal, zeroed for no measurement or a glitch.
	assign diff    = measured_q - nominal_q;
	assign err_ok  = (measured_q != 32'd0) && ($signed(diff) <= ERR_LIMIT)
		&& ($signed(diff) >= -ERR_LIMIT);
	assign err     = err_ok ? $signed(diff[ERR_W-1:0]) : '0;
	assign err_neg = err[ERR_W-1];
	assign mag     = err_neg ? 11'(-err) : 11'(err);

	// Small errors are halved toward zero; large ones use the signed square.
	assign half_e = (err + $signed(ERR_W'(err_neg))) >>> 1;
	assign adj = (mag > 11'(SQUARE_MIN))
		? (err_neg ? (16'd0 - prod_q[15:0]) : prod_q[15:0])
		: {{(16 - ERR_W){half_e[ERR_W-1]}}, half_e};

	// Until the ring is full the entry being overwritten counts as zero; the RAM has no reset.
	assign ring_full = (samples_q == SAMP_W'(RING_DEPTH));
	assign old_ext   = ring_full
		? {{(SUM_W - ERR_W){ram_rdata[ERR_W-1]}}, ram_rdata} : '0;
	assign err_ext   = {{(SUM_W - ERR_W){err[ERR_W-1]}}, err};

	assign sum_neg      = sum_q[SUM_W-1];
	assign sum_abs_full = sum_neg ? -sum_q : sum_q;
	assign sum_abs      = sum_abs_full[SUM_W-2:0];

	assign num_w     = (NUM_W'(prod_q) << SCALE_SPLIT) + NUM_W'(nlo_q);
	assign samp_ext  = 32'(samples_q);
	assign div_start = (state_q == ST_DSTART) && (samples_q != '0)
		&& (nominal_q != 32'd0);

	always_comb begin
		unique case (state_q)
			ST_MULW: begin
				mul_a = 32'(cpw_q);
				mul_b = wrap_q;
			end
			ST_SQUARE: begin
				mul_a = 32'(mag);
				mul_b = 32'(mag);
			end
			ST_DEN: begin
				mul_a = nominal_q;
				mul_b = samp_ext;
			end
			ST_NLO: begin
				mul_a = 32'(sum_abs);
				mul_b = SCALE_LO;
			end
			ST_NHI: begin
				mul_a = 32'(sum_abs);
				mul_b = SCALE_HI;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pfd_ram #(
		.WIDTH(ERR_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_TRIM),
		.waddr (ptr_q),
		.wdata (err),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	pfd_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_w),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Configuration registers. The PWM start value only matters at reset, where
	// it is always the reset value, so a write to it has no lasting effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			cpw_q     <= COUNTS_PER_WRAP_RST;
			nominal_q <= NOMINAL_HZ_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ENABLE_ADJUST:   enable_q  <= cfg.data[0];
				REG_COUNTS_PER_WRAP: cpw_q     <= cfg.data[16:0];
				REG_NOMINAL_HZ:      nominal_q <= cfg.data;
				REG_PWM_START:       ;
				default:             ;
			endcase
		end
	end

	// Sequencer and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wrap_q     <= '0;
			prev_cap_q <= '0;
			last_ms_q  <= '0;
			measured_q <= '0;
			first_q    <= 1'b1;
			pwm_q      <= PWM_START_RST;
			ptr_q      <= '0;
			sum_q      <= '0;
			samples_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (evt_acc) begin
						if (!evt.func) begin
							wrap_q  <= wrap_q + 32'd1;
							state_q <= ST_DEN;
						end else if (enable_q && pps_ok) begin
							state_q <= ST_MULW;
						end else begin
							if (enable_q) begin
								prev_cap_q <= evt.capture_count;
								wrap_q     <= '0;
								last_ms_q  <= evt.now_ms;
								first_q    <= 1'b0;
							end
							state_q <= ST_DEN;
						end
					end
				end
				ST_MULW: state_q <= ST_MEAS;
				ST_MEAS: begin
					measured_q <= 32'(cap_q) - 32'(prev_cap_q) + prod_q[31:0];
					prev_cap_q <= cap_q;
					wrap_q     <= '0;
					last_ms_q  <= now_q;
					first_q    <= 1'b0;
					state_q    <= ST_SQUARE;
				end
				ST_SQUARE: state_q <= ST_TRIM;
				ST_TRIM: begin
					if (err != '0) begin
						pwm_q <= pwm_q - adj;
					end
					sum_q <= sum_q - old_ext + err_ext;
					if (ptr_q == PTR_W'(RING_DEPTH - 1)) begin
						ptr_q <= '0;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
					if (!ring_full) begin
						samples_q <= samples_q + SAMP_W'(1);
					end
					state_q <= ST_DEN;
				end
				ST_DEN:    state_q <= ST_NLO;
				ST_NLO:    state_q <= ST_NHI;
				ST_NHI:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= div_start ? ST_DWAIT : ST_FIN;
				ST_DWAIT: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!res_valid_q || res.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Work registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (evt_acc) begin
			cap_q <= evt.capture_count;
			now_q <= evt.now_ms;
		end
		if (state_q == ST_NLO) begin
			den_q <= prod_q[DEN_W-1:0];
		end
		if (state_q == ST_NHI) begin
			nlo_q <= prod_q;
		end
		if (state_q == ST_DSTART) begin
			avg_q <= (samples_q == '0) ? AVG_NO_SAMPLES : 32'd0;
		end
		if (state_q == ST_DWAIT && div_done) begin
			avg_q <= sum_neg ? (32'd0 - div_quot) : div_quot;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!res_valid_q || res.ready)) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!res_valid_q || res.ready)) begin
			res_meas_q <= measured_q;
			res_err_q  <= err;
			res_pwm_q  <= pwm_q;
			res_avg_q  <= avg_q;
			res_samp_q <= samp_ext[7:0];
		end
	end

	assign res.valid              = res_valid_q;
	assign res.measured_cycles    = res_meas_q;
	assign res.freq_error         = res_err_q;
	assign res.pwm_compare        = res_pwm_q;
	assign res.avg_error_ppb_x100 = $signed(res_avg_q);
	assign res.sample_count       = res_samp_q;

endmodule

// File: hdl/pfd_checker.sv
// ----------------------------------------------------------------------------
// PPS frequency discipline checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pfd_checker
	import pfd_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               evt_valid,
	input logic               evt_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic        [31:0] measured_cycles,
	input logic signed [11:0] freq_error,
	input logic        [7:0]  sample_count
);

	// The block is busy in the cycle after an accepted event.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_ready) |=> !evt_ready)
		else $error("event channel ready right after an accepted event");

	// The error is held to the glitch window.
	a_error_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (freq_error <= 12'sd2000) && (freq_error >= -12'sd2000))
		else $error("frequency error outside the glitch window");

	// Without a measurement there is no error.
	a_no_meas_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && measured_cycles == 32'd0) |-> (freq_error == 12'sd0))
		else $error("nonzero error without a measurement");

	// A stalled result word holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(measured_cycles)
			&& $stable(sample_count))
		else $error("stalled result word changed");

	// The fill count never passes the ring depth.
	a_sample_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (32'(sample_count) <= 32'(RING_DEPTH)))
		else $error("sample count beyond ring depth");

endmodule

bind pps_frequency_discipline pfd_checker #(
	.RING_DEPTH(RING_DEPTH)
) u_pfd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.evt_valid       (evt.valid),
	.evt_ready       (evt.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.measured_cycles (res.measured_cycles),
	.freq_error      (res.freq_error),
	.sample_count    (res.sample_count)
);

// File: tb/pps_frequency_discipline_test.sv
// ----------------------------------------------------------------------------
// PPS frequency discipline testbench
// Feeds timer-wrap and PPS capture events through the discipline loop. A
// predictor keeps its own copy of the loop state and checks every status word.
// The predictor advances when an event is accepted. Its result is checked in
// order against the result words under several register setups and several
// idle and stall patterns.
// ----------------------------------------------------------------------------
module pps_frequency_discipline_test;
	import pfd_pkg::*;

	localparam int     RING         = RING_DEPTH_DEF;
	localparam int     STALL_LIMIT  = 5000;
	localparam int     DRAIN_CYCLES = 100;
	localparam longint PPB_X100     = 64'd100_000_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

	typedef enum logic {EV_WRAP = 1'b0, EV_PPS = 1'b1} ev_kind_t;
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		ev_kind_t    kind;
		logic [15:0] capture;
		logic [31:0] stamp_ms;
	} pps_event_t;

	typedef struct {
		logic [31:0]        measured;
		logic signed [11:0] freq_error;
		logic [15:0]        pwm;
		logic signed [31:0] avg_ppb;
		logic [7:0]         samples;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pfd_evt_if evt();
	pfd_res_if res();
	pfd_cfg_if cfg();

	pps_frequency_discipline u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.res    (res),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	pps_event_t pending_events[$];
	status_t    expected_status[$];
	idle_mode_t idle_mode = IDLE_NONE;
	int events_queued = 0;
	int events_sent = 0;
	int events_taken = 0;
	int words_checked = 0;
	int ring_entries = 0;
	int phases_run = 0;
	int failures = 0;
	int quiet_cycles = 0;

	// Loop predictor: registers and state.
	logic        adjust_on;
	logic [16:0] wrap_span;
	logic [31:0] nominal;
	logic [15:0] pwm_start_reg;
	logic [31:0] wraps_seen;
	logic [15:0] last_capture;
	logic [31:0] last_pps_stamp;
	logic [31:0] cycles_per_pps;
	bit          awaiting_first;
	logic [15:0] pwm_trim;
	int          err_ring[RING];
	int          ring_idx;
	int          err_sum;
	int          ring_fill;

	// Stimulus generator view of the loop, used to build well-formed seconds.
	bit          gen_enable = 1'b0;
	longint      gen_span = 65536;
	logic [31:0] gen_nominal = NOMINAL_HZ_RST;
	logic [15:0] gen_prev = '0;
	logic [31:0] gen_last = '0;

	function void reset_loop_model();
		adjust_on      = 1'b0;
		wrap_span      = COUNTS_PER_WRAP_RST;
		nominal        = NOMINAL_HZ_RST;
		pwm_start_reg  = PWM_START_RST;
		wraps_seen     = '0;
		last_capture   = '0;
		last_pps_stamp = '0;
		cycles_per_pps = '0;
		awaiting_first = 1'b1;
		pwm_trim       = pwm_start_reg;
		foreach (err_ring[i])
			err_ring[i] = 0;
		ring_idx  = 0;
		err_sum   = 0;
		ring_fill = 0;
	endfunction

	function automatic int freq_offset();
		logic signed [31:0] diff;
		if (cycles_per_pps == 0)
			return 0;
		diff = cycles_per_pps - nominal;
		if (diff > ERR_LIMIT || diff < -ERR_LIMIT)
			return 0;
		return diff;
	endfunction

	function automatic logic signed [31:0] avg_error();
		longint num, den;
		if (ring_fill == 0)
			return AVG_NO_SAMPLES;
		if (nominal == 0)
			return 0;
		num = longint'(err_sum) * PPB_X100;
		den = longint'(nominal) * longint'(ring_fill);
		return 32'(num / den);
	endfunction

	function automatic status_t discipline_step(pps_event_t ev);
		int e, mag, adj;
		status_t s;
		if (ev.kind == EV_WRAP) begin
			wraps_seen = wraps_seen + 1;
		end else if (adjust_on) begin
			if (!awaiting_first && (ev.stamp_ms - last_pps_stamp) < PPS_TIMEOUT_MS) begin
				cycles_per_pps = 32'(ev.capture) - 32'(last_capture)
					+ 32'(wrap_span) * wraps_seen;
				e = freq_offset();
				if (e != 0) begin
					mag = (e < 0) ? -e : e;
					adj = (mag > SQUARE_MIN) ? mag * e : e / 2;
					pwm_trim = pwm_trim - 16'(adj);
				end
				err_sum = err_sum - err_ring[ring_idx] + e;
				err_ring[ring_idx] = e;
				ring_idx = (ring_idx + 1) % RING;
				if (ring_fill < RING)
					ring_fill++;
				ring_entries++;
			end
			last_capture   = ev.capture;
			wraps_seen     = '0;
			last_pps_stamp = ev.stamp_ms;
			awaiting_first = 1'b0;
		end
		s.measured   = cycles_per_pps;
		s.freq_error = 12'(freq_offset());
		s.pwm        = pwm_trim;
		s.avg_ppb    = avg_error();
		s.samples    = 8'(ring_fill);
		return s;
	endfunction

	function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	function bit hold_off(bit recv_side);
		case (idle_mode)
			IDLE_SEND: return !recv_side && $urandom_range(0, 99) < 77;
			IDLE_RECV: return recv_side && $urandom_range(0, 99) < 77;
			IDLE_BOTH: return $urandom_range(0, 99) < 23;
			default:   return 1'b0;
		endcase
	endfunction

	function void add_event(ev_kind_t kind, logic [15:0] capture, logic [31:0] stamp);
		pps_event_t ev;
		ev.kind     = kind;
		ev.capture  = capture;
		ev.stamp_ms = stamp;
		pending_events.push_back(ev);
		events_queued++;
		if (kind == EV_PPS && gen_enable) begin
			gen_prev = capture;
			gen_last = stamp;
		end
	endfunction

	// One PPS second: a run of wraps, then a capture placed so that the
	// measurement lands near nominal plus a chosen error.
	function void add_second();
		int          err, n, pick, dt;
		longint      target, rest, cap_l;
		logic [31:0] tgt;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			err = int'($urandom_range(0, 40)) - 20;
		else if (pick < 90)
			err = int'($urandom_range(0, 4000)) - 2000;
		else if (pick < 95)
			err = int'($urandom_range(1990, 2100));
		else
			err = -int'($urandom_range(1990, 2100));
		tgt = gen_nominal + 32'(err);
		target = longint'($signed(tgt));
		n = 0;
		rest = target;
		if (target > 0 && gen_span != 0) begin
			n = int'(target / gen_span);
			if (n > 8)
				n = $urandom_range(0, 8);
			rest = target - longint'(n) * gen_span;
			if (longint'(gen_prev) + rest > 65535 && rest - gen_span >= -longint'(gen_prev)) begin
				n++;
				rest = rest - gen_span;
			end
		end
		if (gen_span == 0)
			n = $urandom_range(0, 3);
		// When the capture cannot fit in 16 bits, a late PPS moves the anchor first.
		cap_l = longint'(gen_prev) + rest;
		if ((cap_l < 0 || cap_l > 65535) && rest >= -65535 && rest <= 65535) begin
			if (rest >= 0)
				add_event(EV_PPS, 16'($urandom_range(0, 65535 - int'(rest))), gen_last + 32'd2000);
			else
				add_event(EV_PPS, 16'($urandom_range(int'(-rest), 65535)), gen_last + 32'd2000);
			cap_l = longint'(gen_prev) + rest;
		end
		if (cap_l < 0)
			cap_l = 0;
		else if (cap_l > 65535)
			cap_l = 65535;
		repeat (n)
			add_event(EV_WRAP, 16'($urandom), gen_last + 32'($urandom_range(1, 999)));
		pick = $urandom_range(0, 99);
		if (pick < 85)
			dt = $urandom_range(900, 1299);
		else if (pick < 95)
			dt = $urandom_range(1300, 3000);
		else
			dt = $urandom;
		add_event(EV_PPS, 16'(cap_l), gen_last + 32'(dt));
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_events.size() != 0 || events_taken != events_sent
			|| expected_status.size() != 0)
			@(posedge clk);
		// A result register may still be settling after the last word.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(bit enable, logic [16:0] span, logic [31:0] nom,
		logic [15:0] pwm_init, idle_mode_t mode, int count);
		int start;
		drain();
		write_reg(REG_ENABLE_ADJUST, 32'(enable));
		write_reg(REG_COUNTS_PER_WRAP, {15'($urandom), span});
		write_reg(REG_NOMINAL_HZ, nom);
		write_reg(REG_PWM_START, {16'($urandom), pwm_init});
		if ($urandom_range(0, 1))
			write_reg(REG_UNUSED, $urandom);
		gen_enable  = enable;
		gen_span    = span;
		gen_nominal = nom;
		idle_mode   = mode;
		phases_run++;
		start = events_queued;
		while (events_queued - start < count) begin
			if ($urandom_range(0, 99) < 75)
				add_second();
			else
				add_event(ev_kind_t'($urandom_range(0, 1)), 16'($urandom), $urandom);
		end
	endtask

	// Event driver and result ready: a word is held until taken, gaps and stalls come from the idle mode.
	always @(negedge clk) begin
		pps_event_t nxt;
		if (!arst_n) begin
			evt.valid         <= 1'b0;
			evt.func          <= 1'b0;
			evt.capture_count <= '0;
			evt.now_ms        <= '0;
			res.ready         <= 1'b0;
		end else begin
			if (!evt.valid || events_taken == events_sent) begin
				if (pending_events.size() != 0 && !hold_off(1'b0)) begin
					nxt = pending_events.pop_front();
					evt.valid         <= 1'b1;
					evt.func          <= nxt.kind;
					evt.capture_count <= nxt.capture;
					evt.now_ms        <= nxt.stamp_ms;
					events_sent++;
				end else begin
					evt.valid <= 1'b0;
				end
			end
			res.ready <= !hold_off(1'b1);
		end
	end

	// Monitor: predicts on accepted events, checks result words, tracks config.
	always @(posedge clk) begin
		status_t    want;
		pps_event_t ev;
		bit         moved;
		moved = 1'b0;
		if (cfg.valid && cfg.ready) begin
			moved = 1'b1;
			case (cfg.index)
				REG_ENABLE_ADJUST:   adjust_on = cfg.data[0];
				REG_COUNTS_PER_WRAP: wrap_span = cfg.data[16:0];
				REG_NOMINAL_HZ:      nominal = cfg.data;
				REG_PWM_START:       pwm_start_reg = cfg.data[15:0];
				default: ;
			endcase
		end
		if (evt.valid && evt.ready) begin
			moved = 1'b1;
			ev.kind     = ev_kind_t'(evt.func);
			ev.capture  = evt.capture_count;
			ev.stamp_ms = evt.now_ms;
			expected_status.push_back(discipline_step(ev));
			events_taken++;
		end
		if (res.valid && res.ready) begin
			moved = 1'b1;
			if (expected_status.size() == 0) begin
				$error("result word with no event outstanding");
				failures++;
			end else begin
				want = expected_status.pop_front();
				check_field("measured_cycles", want.measured, res.measured_cycles);
				check_field("freq_error", want.freq_error, res.freq_error);
				check_field("pwm_compare", want.pwm, res.pwm_compare);
				check_field("avg_error_ppb_x100", want.avg_ppb, res.avg_error_ppb_x100);
				check_field("sample_count", want.samples, res.sample_count);
				words_checked++;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		reset_loop_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings, loop disabled: captures must leave the state alone.
		add_event(EV_WRAP, 16'hFFFF, 32'hFFFF_FFFF);
		add_event(EV_PPS, 16'hFFFF, 32'hFFFF_FFFF);
		add_event(EV_PPS, 16'h0000, 32'h0000_0000);
		drain();

		// Small second, nominal 5000 counts, with 1000-count wraps; the late start
		// value write must not touch the running trim.
		write_reg(REG_ENABLE_ADJUST, 32'd1);
		write_reg(REG_COUNTS_PER_WRAP, 32'd1000);
		write_reg(REG_NOMINAL_HZ, 32'd5000);
		write_reg(REG_PWM_START, 32'h0000_FFFF);
		write_reg(REG_UNUSED, 32'h1234_5678);
		gen_enable = 1'b1;
		add_event(EV_PPS, 16'd100, 32'd1000);      // first capture only anchors
		add_event(EV_PPS, 16'd5100, 32'd2000);     // exact second, zero error
		add_event(EV_PPS, 16'd10103, 32'd2999);    // small positive error, halved
		add_event(EV_PPS, 16'd15099, 32'd3100);    // error just above the square limit
		add_event(EV_PPS, 16'd20099, 32'd4400);    // exactly at the timeout
		add_event(EV_WRAP, 16'd0, 32'd4500);
		add_event(EV_WRAP, 16'd0, 32'd4600);
		add_event(EV_PPS, 16'd25099, 32'd5699);    // just inside the timeout, +2000
		add_event(EV_PPS, 16'd32100, 32'd6000);    // +2001 is a glitch
		add_event(EV_PPS, 16'd32100, 32'd6100);    // zero measurement
		add_event(EV_PPS, 16'd35100, 32'd6200);    // -2000
		add_event(EV_PPS, 16'd40099, 32'd6300);    // -1 rounds to no trim
		add_event(EV_PPS, 16'hFFFF, 32'hFFFF_FC00);
		repeat (6)
			add_event(EV_WRAP, 16'hFFFF, 32'hFFFF_FD00);
		add_event(EV_PPS, 16'd64535, 32'h0000_0100); // millisecond counter wraps
		add_event(EV_PPS, 16'd0, 32'h0000_0200);     // capture below previous one

		run_phase(1'b1, 17'd65536, 32'd200000, 16'h0000, IDLE_NONE, 200);
		run_phase(1'b1, 17'd1, 32'd30, 16'hFFFF, IDLE_SEND, 190);
		run_phase(1'b1, 17'd0, 32'd3000, 16'($urandom), IDLE_RECV, 190);
		run_phase(1'b1, 17'($urandom_range(2, 65535)), 32'($urandom_range(10000, 400000)),
			16'($urandom), IDLE_BOTH, 190);
		run_phase(1'b1, 17'd7, 32'd0, 16'($urandom), IDLE_NONE, 190);
		run_phase(1'b1, 17'd65536, 32'hFFFF_FFFF, 16'($urandom), IDLE_BOTH, 190);
		run_phase(1'b0, 17'd4096, NOMINAL_HZ_RST, 16'($urandom), IDLE_RECV, 150);
		run_phase(1'b1, 17'd50000, 32'd1, 16'($urandom), IDLE_SEND, 190);
		drain();

		$display("Checked %0d status words from %0d events over %0d register setups.",
			words_checked, events_taken, phases_run);
		$display("The error ring took %0d measured seconds.", ring_entries);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/pfd_pkg.sv
hdl/pfd_if.sv
hdl/pfd_ram.sv
hdl/pfd_div.sv
hdl/pps_frequency_discipline.sv
hdl/pfd_checker.sv
tb/pps_frequency_discipline_test.sv
